[sv/ddsg_pkg.sv]
// Shared types, codes and constants of the differential-drive step generator.
`default_nettype none

package ddsg_pkg;

	localparam int STEPS_PER_SEQ = 8;
	localparam int SEQ_W = (STEPS_PER_SEQ > 1) ? $clog2(STEPS_PER_SEQ) : 1;

	localparam logic [6:0] MAX_PERIOD_US = 7'd100;
	localparam logic [35:0] PERIOD_NUM = 36'd960000000;

	localparam int DIV_DW = 36;
	localparam int DIV_SW = 32;
	localparam int DIV_CW = $clog2(DIV_DW);

	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_STEPS_PER_REV = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_MIN_PWM_SPEED = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_MAX_PWM_SPEED = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_PWM_LOW_LEVEL = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_PWM_HIGH_LEVEL = 3'd4;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_TRANS = 2'd1,
		OP_STOP  = 2'd2,
		OP_RUN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIV_PERIOD = 2'd0,
		DIV_RATIO  = 2'd1,
		DIV_LEVEL  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     take_in;
		logic     prep;
		logic     start_div;
		div_sel_t div_sel;
		logic     store_period;
		logic     store_ratio;
		logic     mul;
		logic     sum;
		logic     store_level;
		logic     slow_sel;
		logic     emit;
		logic     emit_idle;
		logic     last;
	} cmd_t;

	typedef struct packed {
		logic fast_zero;
		logic div_done;
		logic out_free;
	} status_t;

	// first member sits in the top bits: right_stop ends up at bit 0
	typedef struct packed {
		logic [6:0]  period_us;
		logic [15:0] slow_pwm;
		logic        slow_forward;
		logic        slow_step;
		logic [15:0] fast_pwm;
		logic        fast_forward;
		logic        fast_is_right;
		logic        idle_wait;
		logic        left_stop;
		logic        right_stop;
	} out_t;

endpackage

`default_nettype wire

[sv/ddsg_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module ddsg_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ddsg_pkg::DIV_DW-1:0]   dividend,
	input  wire logic [ddsg_pkg::DIV_SW-1:0]   divisor,
	output logic                               done,
	output logic [ddsg_pkg::DIV_DW-1:0]        quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [ddsg_pkg::DIV_CW-1:0] cnt_q;
	logic [ddsg_pkg::DIV_DW-1:0] dvd_q;
	logic [ddsg_pkg::DIV_SW-1:0] rem_q;
	logic [ddsg_pkg::DIV_SW-1:0] dsr_q;

	logic [ddsg_pkg::DIV_SW:0]   trial;
	logic [ddsg_pkg::DIV_SW:0]   diff;
	logic                        ge;

	always_comb begin
		trial = {rem_q, dvd_q[ddsg_pkg::DIV_DW-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == ddsg_pkg::DIV_CW'(ddsg_pkg::DIV_DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ddsg_pkg::DIV_DW-2:0], ge};
			rem_q <= ge ? diff[ddsg_pkg::DIV_SW-1:0] : trial[ddsg_pkg::DIV_SW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

[sv/ddsg_ctrl.sv]
// Sequencer of the step generator: command decode, division order, entry count.
`default_nettype none

module ddsg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       opcode,
	input  wire ddsg_pkg::status_t status,
	output ddsg_pkg::cmd_t        cmd
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_PREP    = 11'b00000000010,
		S_CHK     = 11'b00000000100,
		S_PDIV    = 11'b00000001000,
		S_RDIV    = 11'b00000010000,
		S_PMUL    = 11'b00000100000,
		S_PSUM    = 11'b00001000000,
		S_LSTART  = 11'b00010000000,
		S_LWAIT   = 11'b00100000000,
		S_EMIT    = 11'b01000000000,
		S_IDLEOUT = 11'b10000000000
	} state_t;

	state_t                     state_q, state_d;
	logic                       slow_q, slow_d;
	logic [ddsg_pkg::SEQ_W-1:0] cnt_q, cnt_d;
	logic                       at_last;

	assign at_last = cnt_q == ddsg_pkg::SEQ_W'(ddsg_pkg::STEPS_PER_SEQ - 1);

	always_comb begin
		state_d  = state_q;
		slow_d   = slow_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					if (opcode == ddsg_pkg::OP_RUN) state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = S_CHK;
			end
			S_CHK: begin
				if (status.fast_zero) begin
					state_d = S_IDLEOUT;
				end else begin
					cmd.start_div = 1'b1;
					cmd.div_sel   = ddsg_pkg::DIV_PERIOD;
					state_d       = S_PDIV;
				end
			end
			S_PDIV: begin
				if (status.div_done) begin
					cmd.store_period = 1'b1;
					cmd.start_div    = 1'b1;
					cmd.div_sel      = ddsg_pkg::DIV_RATIO;
					state_d          = S_RDIV;
				end
			end
			S_RDIV: begin
				slow_d = 1'b0;
				if (status.div_done) begin
					cmd.store_ratio = 1'b1;
					state_d         = S_PMUL;
				end
			end
			S_PMUL: begin
				cmd.mul      = 1'b1;
				cmd.slow_sel = slow_q;
				state_d      = S_PSUM;
			end
			S_PSUM: begin
				cmd.sum = 1'b1;
				state_d = S_LSTART;
			end
			S_LSTART: begin
				cmd.start_div = 1'b1;
				cmd.div_sel   = ddsg_pkg::DIV_LEVEL;
				state_d       = S_LWAIT;
			end
			S_LWAIT: begin
				cmd.slow_sel = slow_q;
				if (status.div_done) begin
					cmd.store_level = 1'b1;
					if (slow_q) begin
						state_d = S_EMIT;
					end else begin
						slow_d  = 1'b1;
						state_d = S_PMUL;
					end
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = at_last;
					cnt_d    = cnt_q + 1'b1;
					if (at_last) state_d = S_IDLE;
				end
			end
			S_IDLEOUT: begin
				if (status.out_free) begin
					cmd.emit_idle = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slow_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			slow_q  <= slow_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

[sv/ddsg_dp.sv]
// Datapath: settings, wheel speeds, period/ratio/PWM arithmetic, step accumulator, output word.
`default_nettype none

module ddsg_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ddsg_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [15:0]                   cfg_wdata,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [15:0]            value_a,
	input  wire logic signed [15:0]            value_b,
	input  wire ddsg_pkg::cmd_t                cmd,
	output ddsg_pkg::status_t                  status,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output ddsg_pkg::out_t                     out_data,
	output logic                               out_last
);

	// settings
	logic [15:0] spr_q;
	logic [14:0] min_q;
	logic [14:0] max_q;
	logic [15:0] lo_q;
	logic [15:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= 16'd200;
			min_q <= 15'd0;
			max_q <= 15'd16000;
			lo_q  <= 16'd0;
			hi_q  <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				ddsg_pkg::CFG_STEPS_PER_REV:  spr_q <= cfg_wdata;
				ddsg_pkg::CFG_MIN_PWM_SPEED:  min_q <= cfg_wdata[14:0];
				ddsg_pkg::CFG_MAX_PWM_SPEED:  max_q <= cfg_wdata[14:0];
				ddsg_pkg::CFG_PWM_LOW_LEVEL:  lo_q  <= cfg_wdata;
				ddsg_pkg::CFG_PWM_HIGH_LEVEL: hi_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// wheel speeds
	logic signed [15:0] rspd_q, lspd_q;
	logic signed [16:0] half;
	logic signed [17:0] lsum, rsum;
	logic signed [15:0] lsat, rsat;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) r = 16'sh7FFF;
		else if (v < -18'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	always_comb begin
		// rotation / 2, rounded toward zero
		half = $signed({value_b[15], value_b} + {16'd0, value_b[15]}) >>> 1;
		lsum = {{2{value_a[15]}}, value_a} + {half[16], half};
		rsum = {{2{value_a[15]}}, value_a} - {half[16], half};
		lsat = sat16(lsum);
		rsat = sat16(rsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rspd_q <= '0;
			lspd_q <= '0;
		end else if (cmd.take_in) begin
			case (ddsg_pkg::op_t'(opcode))
				ddsg_pkg::OP_SET: begin
					rspd_q <= value_a;
					lspd_q <= value_b;
				end
				ddsg_pkg::OP_TRANS: begin
					rspd_q <= rsat;
					lspd_q <= lsat;
				end
				ddsg_pkg::OP_STOP: begin
					rspd_q <= '0;
					lspd_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// fast/slow selection and period product
	logic [15:0] ar, al, fast_c, slow_c;
	logic        fr_c;
	logic [15:0] fast_q, slow_q;
	logic        fr_q, ffwd_q, sfwd_q, rstop_q, lstop_q;
	logic [31:0] prod_q;

	always_comb begin
		ar     = rspd_q[15] ? 16'(-rspd_q) : rspd_q;
		al     = lspd_q[15] ? 16'(-lspd_q) : lspd_q;
		fr_c   = ar > al;
		fast_c = fr_c ? ar : al;
		slow_c = fr_c ? al : ar;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			fast_q  <= fast_c;
			slow_q  <= slow_c;
			fr_q    <= fr_c;
			ffwd_q  <= fr_c ? !rspd_q[15] : !lspd_q[15];
			sfwd_q  <= fr_c ? !lspd_q[15] : !rspd_q[15];
			rstop_q <= rspd_q == '0;
			lstop_q <= lspd_q == '0;
			prod_q  <= spr_q * fast_c;
		end
	end

	// PWM line: total = lo*den + (hi-lo)*(speed-min), then total/den
	logic signed [15:0] den;
	logic [15:0]        den_mag;
	logic [15:0]        spd;
	logic signed [16:0] lo_s, hmlo, spd_min;
	logic signed [32:0] m1_s1;
	logic signed [33:0] m2_s1;
	logic signed [34:0] total;
	logic [35:0]        tot_mag_s2;
	logic               tot_neg_s2;

	always_comb begin
		den     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		den_mag = den[15] ? 16'(-den) : den;
		spd     = cmd.slow_sel ? slow_q : fast_q;
		lo_s    = $signed({1'b0, lo_q});
		hmlo    = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
		spd_min = $signed({1'b0, spd}) - $signed({2'b0, min_q});
		total   = 35'(m1_s1) + 35'(m2_s1);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			m1_s1 <= lo_s * den;
			m2_s1 <= hmlo * spd_min;
		end
		if (cmd.sum) begin
			tot_neg_s2 <= total[34];
			tot_mag_s2 <= total[34] ? 36'(-total) : 36'(total);
		end
	end

	// shared divider
	logic [ddsg_pkg::DIV_DW-1:0] dvd;
	logic [ddsg_pkg::DIV_SW-1:0] dsr;
	logic                        div_done;
	logic [ddsg_pkg::DIV_DW-1:0] quo;

	always_comb begin
		case (cmd.div_sel)
			ddsg_pkg::DIV_PERIOD: begin
				dvd = ddsg_pkg::PERIOD_NUM;
				dsr = prod_q;
			end
			ddsg_pkg::DIV_RATIO: begin
				dvd = {4'd0, slow_q, 16'd0};
				dsr = {16'd0, fast_q};
			end
			ddsg_pkg::DIV_LEVEL: begin
				dvd = tot_mag_s2;
				dsr = {16'd0, den_mag};
			end
			default: begin
				dvd = '0;
				dsr = '0;
			end
		endcase
	end

	ddsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (dvd),
		.divisor  (dsr),
		.done     (div_done),
		.quotient (quo)
	);

	// quotient to PWM level
	logic signed [36:0] qs;
	logic [15:0]        lvl_a, lvl;

	always_comb begin
		qs = (tot_neg_s2 ^ den[15]) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		if (den == '0) lvl_a = ({1'b0, spd} >= {2'b0, min_q}) ? hi_q : lo_q;
		else if (qs < 0) lvl_a = lo_q;
		else if (qs > 37'sd65535) lvl_a = 16'hFFFF;
		else lvl_a = qs[15:0];
		if (lvl_a < lo_q) lvl = lo_q;
		else if (lvl_a > hi_q) lvl = hi_q;
		else lvl = lvl_a;
	end

	logic [6:0]  period_q;
	logic [16:0] ratio_q;
	logic [15:0] flvl_q, slvl_q;

	always_ff @(posedge clk) begin
		if (cmd.store_period)
			period_q <= (quo > 36'(ddsg_pkg::MAX_PERIOD_US)) ? ddsg_pkg::MAX_PERIOD_US : quo[6:0];
		if (cmd.store_ratio) ratio_q <= quo[16:0];
		if (cmd.store_level) begin
			if (cmd.slow_sel) slvl_q <= lvl;
			else flvl_q <= lvl;
		end
	end

	// step accumulator, Q1.16
	logic [16:0] acc_q;
	logic [17:0] acc_sum;

	assign acc_sum = {1'b0, acc_q} + {1'b0, ratio_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= '0;
		else if (cmd.emit) acc_q <= {1'b0, acc_sum[15:0]};
	end

	// output register
	logic           ovalid_q;
	ddsg_pkg::out_t out_q;
	logic           olast_q;
	ddsg_pkg::out_t step_word, idle_word;

	always_comb begin
		step_word               = '0;
		step_word.right_stop    = rstop_q;
		step_word.left_stop     = lstop_q;
		step_word.fast_is_right = fr_q;
		step_word.fast_forward  = ffwd_q;
		step_word.fast_pwm      = flvl_q;
		step_word.slow_step     = acc_sum[16];
		step_word.slow_forward  = sfwd_q;
		step_word.slow_pwm      = slvl_q;
		step_word.period_us     = period_q;
		idle_word               = '0;
		idle_word.right_stop    = 1'b1;
		idle_word.left_stop     = 1'b1;
		idle_word.idle_wait     = 1'b1;
		idle_word.period_us     = ddsg_pkg::MAX_PERIOD_US;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.emit || cmd.emit_idle) ovalid_q <= 1'b1;
		else if (out_ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q   <= step_word;
			olast_q <= cmd.last;
		end else if (cmd.emit_idle) begin
			out_q   <= idle_word;
			olast_q <= 1'b1;
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = out_q;
	assign out_last  = olast_q;

	assign status.fast_zero = fast_q == '0;
	assign status.div_done  = div_done;
	assign status.out_free  = !ovalid_q || out_ready;

endmodule

`default_nettype wire

[sv/diff_drive_step_generator.sv]
// Top level of the differential-drive step generator.
`default_nettype none

// Two-wheel stepper scheduler. Input words carry an opcode in s_tuser: set both
// speeds, set them from translation/rotation, stop, or run one sequence. Commands
// other than run produce nothing. A run word produces STEPS_PER_SEQ step entries
// (or one idle entry when both wheels stand, ending in tlast). Before its first step
// entry a run makes four divisions in a shared radix-2 divider (period, slow/fast
// ratio, and two PWM levels, one quotient bit per cycle over a 36-bit dividend)
// besides setup and multiplies; the entries then leave one per cycle while m_tready
// is high. The output register lets the next input word be taken while the last
// entry waits. Settings go in through cfg_we/cfg_index/cfg_wdata and should be
// written while idle.
module diff_drive_step_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // value_a[15:0], value_b[31:16]
	input  wire logic [1:0]  s_tuser,   // opcode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// right_stop[0], left_stop[1], idle_wait[2], fast_is_right[3], fast_forward[4],
	// fast_pwm[20:5], slow_step[21], slow_forward[22], slow_pwm[38:23],
	// period_us[45:39], zero pad [47:46]
	output logic [47:0]      m_tdata,
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	ddsg_pkg::cmd_t    cmd;
	ddsg_pkg::status_t status;
	ddsg_pkg::out_t    out_data;

	ddsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.opcode   (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	ddsg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.opcode    (s_tuser),
		.value_a   (s_tdata[15:0]),
		.value_b   (s_tdata[31:16]),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_data};

	// idle entries stand alone and stop both wheels
	a_idle_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_data.idle_wait |->
			m_tlast && out_data.right_stop && out_data.left_stop && !out_data.slow_step)
		else $error("idle entry malformed");

	// period is capped at the maximum
	a_period_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_data.period_us <= ddsg_pkg::MAX_PERIOD_US)
		else $error("period above cap");

	// a stepping entry never flags both wheels stopped
	a_step_moving: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_data.idle_wait |-> !(out_data.right_stop && out_data.left_stop))
		else $error("step entry with both wheels stopped");

endmodule

`default_nettype wire
